FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CHK_PROP(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define CHK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/drsb_pkg.sv
// ----------------------------------------------------------------------------
// drsb_pkg
// Types and constants of the set-dueling RRIP replacement block with stream
// bypass.
// ----------------------------------------------------------------------------
package drsb_pkg;

  // Sequencer states: clearing pass, leader map build, then service.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_LREAD_A,
    ST_LWRITE_A,
    ST_LREAD_B,
    ST_LWRITE_B,
    ST_IDLE,
    ST_EXEC
  } drsb_state_t;

  // Leader kinds of a set.
  localparam logic [1:0] KIND_FOLLOW = 2'd0;
  localparam logic [1:0] KIND_LIP    = 2'd1;
  localparam logic [1:0] KIND_BIP    = 2'd2;

  // Opcodes of an input word.
  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_STRIDE    = 1'b1;

  localparam logic [1:0] RRPV_TOP    = 2'd3;
  localparam logic [1:0] CNT_TOP     = 2'd3;
  localparam logic [1:0] THR_RESET   = 2'd2;
  localparam logic [15:0] STRIDE_RESET = 16'd1024;
  localparam int LEADER_STEP_A = 37;
  localparam int LEADER_STEP_B = 71;
  localparam int LEADER_BASE_B = 13;

endpackage

FILE: hw/rtl/dip_rrip_stream_bypass_replacement_top.sv
// ----------------------------------------------------------------------------
// dip_rrip_stream_bypass_replacement_top
// Set-dueling LIP/BIP insertion on 2-bit RRIP with a per-set stride stream
// detector that bypasses allocation in streaming sets.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_stall   opcode, set_index, way_index,
//                                           address, hit
// out_     output     out_valid / out_stall victim_way, bypassed
// cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// For each word the set row is read from the row memory in the accept cycle
// and is modified and written back in the next one; no new word is taken in
// the write-back cycle. After reset a clearing pass writes all SETS rows,
// then the leader map is built in read and write states; no word is taken
// during both. A stalled result holds the output register and blocks the
// next word.
//
`include "assert_macros.svh"

module dip_rrip_stream_bypass_replacement_top
  import drsb_pkg::*;
#(
  parameter int SETS           = 2048,
  parameter int WAYS           = 16,
  parameter int LEADERS        = 32,
  parameter int SELECTOR_WIDTH = 10,
  parameter int BIMODAL_PERIOD = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [10:0] in_set_index,
  input  logic [3:0]  in_way_index,
  input  logic [63:0] in_address,
  input  logic        in_hit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_victim_way,
  output logic        out_bypassed,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int SET_W   = $clog2(SETS);
  localparam int LEAD_W  = (LEADERS > 1) ? $clog2(LEADERS) : 1;
  localparam int BIM_W   = $clog2(BIMODAL_PERIOD);
  localparam int RRPV_LO = 0;
  localparam int VAL_LO  = 2 * WAYS;
  localparam int ADDR_LO = 3 * WAYS;
  localparam int KNOWN_B = 3 * WAYS + 64;
  localparam int CNT_LO  = 3 * WAYS + 65;
  localparam int ROW_W   = 3 * WAYS + 67;
  localparam logic [SELECTOR_WIDTH-1:0] SEL_MAX = '1;
  localparam logic [SELECTOR_WIDTH-1:0] SEL_MID = SEL_MAX >> 1;
  localparam int MOD_STEPS = 6;

  // Reduce the incoming set index modulo SETS by binary long division.
  function automatic logic [SET_W-1:0] set_mod(input logic [10:0] v);
    int r;
    r = int'(v);
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (r >= (SETS << k)) begin
        r = r - (SETS << k);
      end
    end
    return SET_W'(r);
  endfunction

  // State, configuration and counters.
  drsb_state_t state_r, state_nxt;
  logic [SET_W-1:0]          clr_r, clr_nxt;
  logic [LEAD_W-1:0]         lead_r, lead_nxt;
  logic [SET_W-1:0]          la_r, la_nxt;
  logic [SET_W-1:0]          lb_r, lb_nxt;
  logic [1:0]                thr_r;
  logic [15:0]               stride_r;
  logic [SELECTOR_WIDTH-1:0] psel_r, psel_nxt;
  logic [BIM_W-1:0]          bim_r, bim_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [3:0]                out_way_r, out_way_nxt;
  logic                      out_byp_r, out_byp_nxt;

  // Latched input word.
  logic              op_r;
  logic [SET_W-1:0]  set_r;
  logic [3:0]        way_r;
  logic [63:0]       addr_r;
  logic              hit_r;

  // Memories.
  logic [ROW_W-1:0] row_mem [SETS];
  logic [1:0]       kind_mem [SETS];
  logic [ROW_W-1:0] row_rd_r;
  logic [1:0]       kind_rd_r;
  logic [SET_W-1:0] rd_addr;
  logic             row_we;
  logic [SET_W-1:0] row_waddr;
  logic [ROW_W-1:0] row_wdata;
  logic             kind_we;
  logic [SET_W-1:0] kind_waddr;
  logic [1:0]       kind_wdata;
  logic [ROW_W-1:0] row_exec;
  logic [ROW_W-1:0] row_clear;
  logic             accept;
  logic             out_take;

  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign out_valid      = out_valid_r;
  assign out_victim_way = out_way_r;
  assign out_bypassed   = out_byp_r;

  // Row contents written by the clearing pass.
  always_comb begin
    row_clear = '0;
    for (int w = 0; w < WAYS; w++) begin
      row_clear[RRPV_LO + 2*w +: 2] = RRPV_TOP;
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:    if (clr_r == SET_W'(SETS - 1)) state_nxt = ST_LREAD_A;
      ST_LREAD_A:  state_nxt = ST_LWRITE_A;
      ST_LWRITE_A: state_nxt = ST_LREAD_B;
      ST_LREAD_B:  state_nxt = ST_LWRITE_B;
      ST_LWRITE_B: state_nxt = (lead_r == LEAD_W'(LEADERS - 1)) ? ST_IDLE : ST_LREAD_A;
      ST_IDLE:     if (accept) state_nxt = ST_EXEC;
      ST_EXEC:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_CLEAR;
    endcase
  end

  // Leader address walk: set i*37 and i*71+13, both modulo SETS.
  always_comb begin
    int sa;
    int sb;
    sa = int'(la_r) + LEADER_STEP_A;
    sb = int'(lb_r) + LEADER_STEP_B;
    for (int k = 0; k < 2; k++) begin
      if (sa >= SETS) sa = sa - SETS;
      if (sb >= SETS) sb = sb - SETS;
    end
    la_nxt   = la_r;
    lb_nxt   = lb_r;
    lead_nxt = lead_r;
    clr_nxt  = clr_r;
    if (state_r == ST_CLEAR) begin
      clr_nxt = clr_r + 1'b1;
    end
    if (state_r == ST_LWRITE_B) begin
      la_nxt   = SET_W'(sa);
      lb_nxt   = SET_W'(sb);
      lead_nxt = lead_r + 1'b1;
    end
  end

  // Read address of both memories.
  always_comb begin
    unique case (state_r)
      ST_LREAD_A, ST_LWRITE_A: rd_addr = la_r;
      ST_LREAD_B, ST_LWRITE_B: rd_addr = lb_r;
      ST_IDLE:                 rd_addr = set_mod(in_set_index);
      default:                 rd_addr = set_r;
    endcase
  end

  // Read-modify-write of one set row for a victim request or an update.
  always_comb begin
    logic [1:0]  rv [WAYS];
    logic [WAYS-1:0] vl;
    logic [1:0]  cnt_old;
    logic [1:0]  cnt_new;
    logic        known;
    logic [63:0] last;
    logic [63:0] delta;
    logic        fwd;
    logic [3:0]  has_all;
    logic [3:0]  has_val;
    logic [1:0]  max_all;
    logic [1:0]  max_val;
    logic [1:0]  age;
    logic        any_val;
    int          best;
    logic        way_ok;
    logic        use_bip;
    logic [1:0]  ins;
    cnt_old = row_rd_r[CNT_LO +: 2];
    known   = row_rd_r[KNOWN_B];
    last    = row_rd_r[ADDR_LO +: 64];
    vl      = row_rd_r[VAL_LO +: WAYS];
    cnt_new = cnt_old;
    delta   = '0;
    fwd     = 1'b0;
    way_ok  = 1'b0;
    use_bip = 1'b0;
    ins     = RRPV_TOP;
    has_all = '0;
    has_val = '0;
    for (int w = 0; w < WAYS; w++) begin
      rv[w] = row_rd_r[RRPV_LO + 2*w +: 2];
      has_all[rv[w]] = 1'b1;
      if (vl[w]) has_val[rv[w]] = 1'b1;
    end
    any_val = |vl;
    priority if (has_all[3]) max_all = 2'd3;
    else if (has_all[2]) max_all = 2'd2;
    else if (has_all[1]) max_all = 2'd1;
    else max_all = 2'd0;
    priority if (has_val[3]) max_val = 2'd3;
    else if (has_val[2]) max_val = 2'd2;
    else if (has_val[1]) max_val = 2'd1;
    else max_val = 2'd0;
    age = RRPV_TOP - max_all;

    row_exec    = row_rd_r;
    out_way_nxt = out_way_r;
    out_byp_nxt = out_byp_r;
    psel_nxt    = psel_r;
    bim_nxt     = bim_r;
    best        = 0;

    if (op_r == OP_VICTIM) begin
      out_byp_nxt = 1'b0;
      if (cnt_old >= thr_r) begin
        // Streaming set: highest valid RRPV, last way on ties.
        for (int w = 0; w < WAYS; w++) begin
          if (vl[w] && rv[w] == max_val) best = w;
        end
        if (!any_val) best = 0;
      end else begin
        // Age all ways so the oldest reaches the top, take the first one.
        for (int w = WAYS - 1; w >= 0; w--) begin
          if (rv[w] == max_all) best = w;
          row_exec[RRPV_LO + 2*w +: 2] = rv[w] + age;
        end
      end
      out_way_nxt = best[3:0];
    end else begin
      // Stream detector on the stride from the last recorded address.
      delta   = addr_r - last;
      fwd     = (delta != 64'd0) && (delta < {48'd0, stride_r});
      if (known) begin
        if (fwd) begin
          if (cnt_old != CNT_TOP) cnt_new = cnt_old + 2'd1;
        end else if (cnt_old != 2'd0) begin
          cnt_new = cnt_old - 2'd1;
        end
      end
      row_exec[CNT_LO +: 2]   = cnt_new;
      row_exec[KNOWN_B]       = 1'b1;
      row_exec[ADDR_LO +: 64] = addr_r;
      way_ok      = ({28'd0, way_r} < 32'(WAYS));
      out_way_nxt = 4'd0;
      out_byp_nxt = 1'b0;
      use_bip     = (kind_rd_r == KIND_BIP) ||
                    ((kind_rd_r != KIND_LIP) && (psel_r >= SEL_MID));
      if (!hit_r && cnt_new < thr_r) begin
        if (use_bip) begin
          ins     = (bim_r == '0) ? 2'd0 : RRPV_TOP;
          bim_nxt = (bim_r == BIM_W'(BIMODAL_PERIOD - 1)) ? '0 : bim_r + 1'b1;
        end
        if (kind_rd_r == KIND_LIP && psel_r != SEL_MAX) psel_nxt = psel_r + 1'b1;
        if (kind_rd_r == KIND_BIP && psel_r != '0) psel_nxt = psel_r - 1'b1;
      end
      if (!hit_r && cnt_new >= thr_r) out_byp_nxt = 1'b1;
      for (int w = 0; w < WAYS; w++) begin
        if (way_ok && {28'd0, way_r} == 32'(w)) begin
          if (hit_r) begin
            row_exec[RRPV_LO + 2*w +: 2] = 2'd0;
            row_exec[VAL_LO + w]         = 1'b1;
          end else if (cnt_new >= thr_r) begin
            row_exec[VAL_LO + w]         = 1'b0;
          end else begin
            row_exec[RRPV_LO + 2*w +: 2] = ins;
            row_exec[VAL_LO + w]         = 1'b1;
          end
        end
      end
    end
  end

  // Memory write controls per state.
  always_comb begin
    row_we     = 1'b0;
    row_waddr  = set_r;
    row_wdata  = row_exec;
    kind_we    = 1'b0;
    kind_waddr = clr_r;
    kind_wdata = KIND_FOLLOW;
    out_valid_nxt = out_take ? 1'b0 : out_valid_r;
    unique case (state_r)
      ST_CLEAR: begin
        row_we    = 1'b1;
        row_waddr = clr_r;
        row_wdata = row_clear;
        kind_we   = 1'b1;
      end
      ST_LWRITE_A: begin
        kind_we    = (kind_rd_r == KIND_FOLLOW);
        kind_waddr = la_r;
        kind_wdata = KIND_LIP;
      end
      ST_LWRITE_B: begin
        kind_we    = (kind_rd_r == KIND_FOLLOW);
        kind_waddr = lb_r;
        kind_wdata = KIND_BIP;
      end
      ST_EXEC: begin
        row_we        = 1'b1;
        out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Row and leader memories, registered read.
  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_waddr] <= row_wdata;
    row_rd_r <= row_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (kind_we) kind_mem[kind_waddr] <= kind_wdata;
    kind_rd_r <= kind_mem[rd_addr];
  end

  // Input word capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_opcode;
      set_r  <= set_mod(in_set_index);
      way_r  <= in_way_index;
      addr_r <= in_address;
      hit_r  <= in_hit;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      out_way_r <= out_way_nxt;
      out_byp_r <= out_byp_nxt;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      lead_r      <= '0;
      la_r        <= '0;
      lb_r        <= SET_W'(LEADER_BASE_B % SETS);
      thr_r       <= THR_RESET;
      stride_r    <= STRIDE_RESET;
      psel_r      <= SEL_MID;
      bim_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      lead_r      <= lead_nxt;
      la_r        <= la_nxt;
      lb_r        <= lb_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_EXEC) begin
        psel_r <= psel_nxt;
        bim_r  <= bim_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_THRESHOLD: thr_r    <= cfg_wdata[1:0];
          CFG_STRIDE:    stride_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Checks on the sequencing.
  `CHK_PROP(a_accept_idle, !in_stall |-> state_r == ST_IDLE, "accept outside idle")
  `CHK_PROP(a_accept_exec, accept |=> state_r == ST_EXEC, "accept not followed by exec")
  `CHK_PROP(a_exec_result, state_r == ST_EXEC |=> out_valid_r, "exec gave no result")
  `CHK_PROP(a_exec_slot, state_r == ST_EXEC |-> !out_valid_r, "result slot busy in exec")

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the set-dueling RRIP replacement block with stream bypass
// Feeds victim requests and state updates through a queue-fed driver, keeps
// a cycle-free model of the per-set replacement state, and checks every
// result word field by field in a clocked monitor under varied idling.
// ----------------------------------------------------------------------------
module tb;
  import drsb_pkg::*;

  localparam int NSETS = 2048;
  localparam int NWAYS = 16;
  localparam logic [9:0] SEL_TOP = 10'd1023;
  localparam logic [9:0] SEL_HALF = 10'd511;
  localparam int CYCLE_LIMIT = 900000;

  typedef struct packed {
    logic        opcode;
    logic [10:0] set_index;
    logic [3:0]  way_index;
    logic [63:0] address;
    logic        hit;
  } access_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic       bypassed;
  } choice_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_opcode, in_hit;
  logic [10:0] in_set_index;
  logic [3:0] in_way_index;
  logic [63:0] in_address;
  logic out_valid, out_stall, out_bypassed;
  logic [3:0] out_victim_way;
  logic cfg_we, cfg_index;
  logic [15:0] cfg_wdata;

  dip_rrip_stream_bypass_replacement_top DUT (.*);

  // Model state of the replacement policy.
  logic [1:0]  m_rrpv [NSETS][NWAYS];
  logic        m_valid [NSETS][NWAYS];
  logic [63:0] m_last [NSETS];
  logic        m_known [NSETS];
  logic [1:0]  m_count [NSETS];
  logic [1:0]  m_kind [NSETS];
  logic [9:0]  m_psel;
  logic [4:0]  m_bimodal;
  logic [1:0]  m_threshold;
  logic [15:0] m_stride;

  access_t pending_words[$];
  choice_t expected_choices[$];
  int errors = 0;
  int sender_idle_pct = 0, stall_pct = 0;
  int hold_cycles = 0;
  logic in_taken = 1'b0;
  longint cycle = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic void model_reset();
    int a, b;
    for (int s = 0; s < NSETS; s++) begin
      for (int w = 0; w < NWAYS; w++) begin
        m_rrpv[s][w] = RRPV_TOP;
        m_valid[s][w] = 0;
      end
      m_last[s] = 0; m_known[s] = 0; m_count[s] = 0; m_kind[s] = KIND_FOLLOW;
    end
    for (int i = 0; i < 32; i++) begin
      a = (i * LEADER_STEP_A) % NSETS;
      b = (i * LEADER_STEP_B + LEADER_BASE_B) % NSETS;
      if (m_kind[a] == KIND_FOLLOW) m_kind[a] = KIND_LIP;
      if (m_kind[b] == KIND_FOLLOW) m_kind[b] = KIND_BIP;
    end
    m_psel = SEL_HALF; m_bimodal = 0; m_threshold = THR_RESET; m_stride = STRIDE_RESET;
  endfunction

  // Works out the result of one access and advances the model.
  function automatic choice_t replace_step(access_t a);
    choice_t r;
    int s, w;
    logic [1:0] top, ins, age;
    logic [63:0] d;
    r = '0; s = a.set_index; w = a.way_index;
    if (a.opcode == OP_VICTIM) begin
      if (m_count[s] >= m_threshold) begin
        top = 0;
        for (int i = 0; i < NWAYS; i++)
          if (m_valid[s][i] && m_rrpv[s][i] >= top) begin
            top = m_rrpv[s][i]; r.victim_way = 4'(i);
          end
      end else begin
        top = 0;
        for (int i = 0; i < NWAYS; i++) if (m_rrpv[s][i] > top) top = m_rrpv[s][i];
        age = RRPV_TOP - top;
        for (int i = 0; i < NWAYS; i++) m_rrpv[s][i] = m_rrpv[s][i] + age;
        for (int i = NWAYS - 1; i >= 0; i--)
          if (m_rrpv[s][i] == RRPV_TOP) r.victim_way = 4'(i);
      end
    end else begin
      if (m_known[s]) begin
        d = a.address - m_last[s];
        if (d != 0 && d < {48'd0, m_stride}) begin
          if (m_count[s] < CNT_TOP) m_count[s]++;
        end else if (m_count[s] > 0) m_count[s]--;
      end
      m_last[s] = a.address; m_known[s] = 1;
      if (a.hit) begin
        m_rrpv[s][w] = 0; m_valid[s][w] = 1;
      end else if (m_count[s] >= m_threshold) begin
        m_valid[s][w] = 0; r.bypassed = 1;
      end else begin
        ins = RRPV_TOP;
        if (m_kind[s] != KIND_LIP && (m_kind[s] == KIND_BIP || m_psel >= SEL_HALF)) begin
          ins = (m_bimodal == 0) ? 2'd0 : RRPV_TOP;
          m_bimodal++;
        end
        m_rrpv[s][w] = ins; m_valid[s][w] = 1;
        if (m_kind[s] == KIND_LIP && m_psel < SEL_TOP) m_psel++;
        else if (m_kind[s] == KIND_BIP && m_psel > 0) m_psel--;
      end
    end
    return r;
  endfunction

  // Input handshake seen at the rising edge.
  always @(posedge clk) in_taken <= rst_n && in_valid && !in_stall;

  // Driver: offers the next queued word, holding it while stalled.
  always @(negedge clk) begin
    if (in_taken) begin
      expected_choices.push_back(replace_step(pending_words.pop_front()));
    end
    if (pending_words.size() > 0 && ((in_valid && !in_taken) ? 1'b1
        : $urandom_range(99) >= sender_idle_pct)) begin
      in_valid <= 1;
      {in_opcode, in_set_index, in_way_index, in_address, in_hit} <= pending_words[0];
    end else begin
      in_valid <= 0;
    end
    out_stall <= (hold_cycles > 0) || ($urandom_range(99) < stall_pct);
  end

  // Long receiver hold-off, counted in its own process.
  always @(negedge clk) if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;

  // Monitor: compares each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    choice_t want;
    cycle <= cycle + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_choices.size() == 0) begin
        report("unexpected word", 64'({out_victim_way, out_bypassed}), 64'd0);
      end else begin
        want = expected_choices.pop_front();
        if (out_victim_way !== want.victim_way)
          report("victim_way", 64'(out_victim_way), 64'(want.victim_way));
        if (out_bypassed !== want.bypassed)
          report("bypassed", 64'(out_bypassed), 64'(want.bypassed));
      end
    end
    if (cycle > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic access_t rand_word();
    access_t a;
    a.opcode = 1'($urandom_range(1));
    a.set_index = $urandom_range(7) < 5 ? 11'($urandom_range(15) * 37) : 11'($urandom);
    a.way_index = 4'($urandom);
    a.address = {$urandom, $urandom};
    a.hit = 1'($urandom_range(1));
    return a;
  endfunction

  // Short forward-stride run in one set, mixed with requests.
  task automatic push_stream(input int len);
    access_t a;
    logic [63:0] base;
    a.set_index = $urandom_range(3) == 0 ? 11'($urandom) : 11'($urandom_range(15) * 71 + 13);
    base = {$urandom, $urandom};
    for (int i = 0; i < len; i++) begin
      a.opcode = $urandom_range(2) != 0;
      a.way_index = 4'($urandom);
      base = base + (($urandom_range(5) == 0) ? 64'($urandom_range(70000))
                                              : 64'($urandom_range(80)));
      a.address = base;
      a.hit = $urandom_range(3) == 0;
      pending_words.push_back(a);
    end
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_choices.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == CFG_THRESHOLD) m_threshold = val[1:0];
    else m_stride = val;
  endtask

  initial begin
    access_t a;
    int stalls[4] = '{0, 0, 83, 34};
    int gaps[4] = '{0, 83, 0, 34};
    logic [1:0] thr[4] = '{2'd0, 2'd3, 2'd1, 2'd2};
    logic [15:0] str[4] = '{16'd1, 16'hFFFF, 16'd64, 16'd0};
    rst_n = 0; in_valid = 0; in_opcode = 0; in_set_index = 0; in_way_index = 0;
    in_address = 0; in_hit = 0; out_stall = 0; cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    model_reset();
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1;

    // Directed: empty victim, extremes, hit, streaming bypass, leaders.
    a = '0; pending_words.push_back(a);
    a.set_index = 11'h7FF; pending_words.push_back(a);
    a = '{OP_UPDATE, 11'd0, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1}; pending_words.push_back(a);
    a = '{OP_UPDATE, 11'd0, 4'h0, 64'd0, 1'b0}; pending_words.push_back(a);
    a = '{OP_VICTIM, 11'd0, 4'h0, 64'd0, 1'b0}; pending_words.push_back(a);
    for (int i = 0; i < 5; i++) begin
      a = '{OP_UPDATE, 11'd13, 4'(i), 64'd1000 + i * 8, 1'(i == 0)};
      pending_words.push_back(a);
    end
    a = '{OP_VICTIM, 11'd13, 4'h0, 64'd0, 1'b0}; pending_words.push_back(a);
    for (int i = 0; i < 4; i++) begin
      a = '{OP_UPDATE, 11'(i * 37 + 1), 4'(i), 64'h8000_0000 << i, 1'b0};
      pending_words.push_back(a);
      a.opcode = OP_VICTIM; pending_words.push_back(a);
    end
    drain();

    // Random phases across settings and idling mixes.
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_THRESHOLD, 16'(thr[p]));
      write_reg(CFG_STRIDE, str[p]);
      sender_idle_pct = gaps[p]; stall_pct = stalls[p];
      for (int k = 0; k < 90; k++) begin
        if ($urandom_range(2) == 0) pending_words.push_back(rand_word());
        else push_stream($urandom_range(3, 10));
      end
      if (p == 0) begin
        hold_cycles = 300;
        for (int k = 0; k < 10; k++) pending_words.push_back(rand_word());
      end
      drain();
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
